[sv/ssca_pkg.sv]
// Shared types, constants and lookup tables for the segment sweep clock animator.
`timescale 1ns / 1ps

package ssca_pkg;

	typedef enum logic [1:0] {
		ACT_CLEAR     = 2'd0,
		ACT_SET       = 2'd1,
		ACT_COLON_ON  = 2'd2,
		ACT_COLON_OFF = 2'd3
	} action_t;

	typedef struct packed {
		action_t    action;
		logic [1:0] common_line;
		logic [4:0] segment_line;
	} result_t;

	localparam int MAX_RESULTS = 3;

	typedef struct packed {
		logic [1:0]                   count;
		result_t [MAX_RESULTS-1:0]    res;
	} bundle_t;

	typedef struct packed {
		logic clear;
		logic wr_en;
		logic rd_en;
	} trail_ctl_t;

	localparam logic       REG_SWEEP_FRAMES    = 1'b0;
	localparam logic [7:0] SWEEP_FRAMES_RESET  = 8'd64;
	localparam logic [2:0] NONE_STROKE         = 3'd7;
	localparam int         COLON_BITS          = 5;
	localparam int         NUM_DIGITS          = 6;

	localparam logic [2:0] STROKE_TABLE [10][8] = '{
		'{3'd0, 3'd7, 3'd5, 3'd1, 3'd3, 3'd4, 3'd7, 3'd2},
		'{3'd1, 3'd7, 3'd7, 3'd7, 3'd2, 3'd7, 3'd7, 3'd7},
		'{3'd0, 3'd1, 3'd6, 3'd4, 3'd7, 3'd7, 3'd7, 3'd3},
		'{3'd0, 3'd1, 3'd6, 3'd7, 3'd7, 3'd7, 3'd2, 3'd3},
		'{3'd5, 3'd7, 3'd6, 3'd1, 3'd7, 3'd7, 3'd7, 3'd2},
		'{3'd0, 3'd7, 3'd5, 3'd7, 3'd6, 3'd7, 3'd2, 3'd3},
		'{3'd0, 3'd7, 3'd5, 3'd4, 3'd3, 3'd2, 3'd7, 3'd6},
		'{3'd0, 3'd7, 3'd7, 3'd1, 3'd7, 3'd7, 3'd2, 3'd7},
		'{3'd0, 3'd5, 3'd6, 3'd2, 3'd3, 3'd4, 3'd7, 3'd1},
		'{3'd0, 3'd5, 3'd6, 3'd1, 3'd7, 3'd7, 3'd2, 3'd3}
	};

	// {common line, segment line}
	localparam logic [6:0] PIXEL_TABLE [6][7] = '{
		'{{2'd1, 5'd18}, {2'd2, 5'd19}, {2'd0, 5'd19}, {2'd1, 5'd18},
		  {2'd0, 5'd18}, {2'd2, 5'd18}, {2'd1, 5'd19}},
		'{{2'd2, 5'd20}, {2'd2, 5'd21}, {2'd1, 5'd21}, {2'd0, 5'd21},
		  {2'd0, 5'd20}, {2'd1, 5'd17}, {2'd1, 5'd20}},
		'{{2'd0, 5'd22}, {2'd2, 5'd23}, {2'd0, 5'd23}, {2'd0, 5'd22},
		  {2'd1, 5'd22}, {2'd2, 5'd22}, {2'd1, 5'd23}},
		'{{2'd2, 5'd1},  {2'd2, 5'd10}, {2'd0, 5'd1},  {2'd0, 5'd0},
		  {2'd1, 5'd0},  {2'd2, 5'd0},  {2'd1, 5'd1}},
		'{{2'd2, 5'd2},  {2'd2, 5'd3},  {2'd0, 5'd4},  {2'd0, 5'd3},
		  {2'd0, 5'd2},  {2'd1, 5'd2},  {2'd1, 5'd3}},
		'{{2'd2, 5'd4},  {2'd2, 5'd5},  {2'd1, 5'd6},  {2'd0, 5'd6},
		  {2'd0, 5'd5},  {2'd1, 5'd4},  {2'd1, 5'd5}}
	};

	function automatic logic [2:0] stroke_of(input logic [3:0] dig, input logic [2:0] idx);
		logic [2:0] s;
		s = NONE_STROKE;
		if (dig < 4'd10) begin
			s = STROKE_TABLE[dig][idx];
		end
		return s;
	endfunction

	function automatic logic [6:0] pixel_of(input logic [2:0] pos, input logic [2:0] stroke);
		logic [6:0] p;
		p = '0;
		if (pos < 3'd6 && stroke != NONE_STROKE) begin
			p = PIXEL_TABLE[pos][stroke];
		end
		return p;
	endfunction

	function automatic logic [2:0] mod6(input logic [4:0] v);
		logic [4:0] r;
		r = v;
		if (r >= 5'd24) begin
			r = r - 5'd24;
		end
		if (r >= 5'd12) begin
			r = r - 5'd12;
		end
		if (r >= 5'd6) begin
			r = r - 5'd6;
		end
		return r[2:0];
	endfunction

	// {tens, ones} of a value below 64
	function automatic logic [7:0] split_digits(input logic [5:0] v);
		logic [2:0] tens;
		logic [6:0] tens_x10;
		logic [5:0] ones;
		tens = 3'(v >= 6'd10) + 3'(v >= 6'd20) + 3'(v >= 6'd30)
			+ 3'(v >= 6'd40) + 3'(v >= 6'd50) + 3'(v >= 6'd60);
		tens_x10 = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0};
		ones = v - tens_x10[5:0];
		return {1'b0, tens, ones[3:0]};
	endfunction

endpackage

[sv/ssca_tick_if.sv]
// Input channel: tick or restart with the current time.
`timescale 1ns / 1ps

interface ssca_tick_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [4:0] hour;
	logic [5:0] minute;
	logic [5:0] second;

	modport source (output valid, cmd, hour, minute, second, input ready);
	modport sink (input valid, cmd, hour, minute, second, output ready);
endinterface

[sv/ssca_res_if.sv]
// Output channel: one display action per transaction.
`timescale 1ns / 1ps

interface ssca_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [1:0] common_line;
	logic [4:0] segment_line;
	logic       last;

	modport source (output valid, action, common_line, segment_line, last, input ready);
	modport sink (input valid, action, common_line, segment_line, last, output ready);
endinterface

[sv/ssca_trail.sv]
// Trail store: slot memory with per-slot written bits and a registered tail read.
`timescale 1ns / 1ps

module ssca_trail
	import ssca_pkg::*;
#(
	parameter int TRAIL_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  trail_ctl_t                     ctl,
	input  logic [$clog2(TRAIL_DEPTH)-1:0] wr_addr,
	input  logic [7:0]                     wr_data,
	input  logic [$clog2(TRAIL_DEPTH)-1:0] rd_addr,
	output logic [7:0]                     slot
);
	logic [7:0]             mem [TRAIL_DEPTH];
	logic [TRAIL_DEPTH-1:0] written_q;
	logic [7:0]             rd_data_q;
	logic                   rd_valid_q;
	logic                   bypass;

	assign bypass = ctl.wr_en && (wr_addr == rd_addr);

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= bypass ? wr_data : mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q  <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				written_q <= '0;
			end
			if (ctl.wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= bypass || (!ctl.clear && written_q[rd_addr]);
			end
		end
	end

	assign slot = {rd_valid_q & rd_data_q[7], rd_data_q[6:0]};
endmodule

[sv/ssca_step.sv]
// Sweep state and per-tick result generation.
`timescale 1ns / 1ps

module ssca_step
	import ssca_pkg::*;
#(
	parameter int TRAIL_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [7:0]                     sweep_frames,
	input  logic                           accept,
	input  logic                           cmd,
	input  logic [4:0]                     hour,
	input  logic [5:0]                     minute,
	input  logic [5:0]                     second,
	input  logic [7:0]                     slot,
	output trail_ctl_t                     trail_ctl,
	output logic [$clog2(TRAIL_DEPTH)-1:0] wr_addr,
	output logic [7:0]                     wr_data,
	output logic [$clog2(TRAIL_DEPTH)-1:0] rd_addr,
	output logic                           load,
	output bundle_t                        bundle
);
	localparam int         AW     = $clog2(TRAIL_DEPTH);
	localparam logic [7:0] DEPTH8 = 8'(TRAIL_DEPTH);

	function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] x);
		return (x == AW'(TRAIL_DEPTH - 1)) ? '0 : x + 1'b1;
	endfunction

	logic [7:0]    frame_count_q;
	logic          sweeping_q;
	logic          colon_next_on_q;
	logic [3:0]    digits_q [NUM_DIGITS];
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;

	logic          start;
	logic [3:0]    digits_e [NUM_DIGITS];
	logic [7:0]    fc_e;
	logic [AW-1:0] head_e;
	logic [AW-1:0] tail_e;
	logic [AW-1:0] tail_n;
	logic          pop;
	logic          colon;
	logic          light;
	logic          in_sweep;
	logic [7:0]    bound;
	logic [2:0]    pos;
	logic [2:0]    stroke;
	logic [6:0]    pixel;
	logic [7:0]    hr_split;
	logic [7:0]    mn_split;
	logic [7:0]    sc_split;
	logic          step;

	always_comb begin
		hr_split = split_digits({1'b0, hour});
		mn_split = split_digits(minute);
		sc_split = split_digits(second);
		start    = !sweeping_q;
		if (start) begin
			digits_e[0] = hr_split[7:4];
			digits_e[1] = hr_split[3:0];
			digits_e[2] = mn_split[7:4];
			digits_e[3] = mn_split[3:0];
			digits_e[4] = sc_split[7:4];
			digits_e[5] = sc_split[3:0];
		end else begin
			digits_e = digits_q;
		end
		fc_e     = start ? 8'd0 : frame_count_q;
		head_e   = start ? '0 : head_q;
		tail_e   = start ? '0 : tail_q;
		pop      = (inc_wrap(head_e) == tail_e);
		tail_n   = pop ? inc_wrap(tail_e) : tail_e;
		colon    = (fc_e[COLON_BITS-1:0] == '0);
		bound    = sweep_frames - DEPTH8;
		light    = (fc_e < bound);
		in_sweep = (fc_e < sweep_frames);
		pos      = mod6(fc_e[7:3]);
		stroke   = stroke_of(digits_e[pos], fc_e[2:0]);
		pixel    = pixel_of(pos, stroke);
	end

	always_comb begin
		logic [1:0] k;
		k      = 2'd0;
		bundle = '0;
		if (pop && slot[7]) begin
			bundle.res[k] = '{action: ACT_CLEAR, common_line: slot[6:5],
				segment_line: slot[4:0]};
			k = k + 2'd1;
		end
		if (colon) begin
			bundle.res[k] = '{action: colon_next_on_q ? ACT_COLON_ON : ACT_COLON_OFF,
				common_line: 2'd0, segment_line: 5'd0};
			k = k + 2'd1;
		end
		if (light && stroke != NONE_STROKE) begin
			bundle.res[k] = '{action: ACT_SET, common_line: pixel[6:5],
				segment_line: pixel[4:0]};
			k = k + 2'd1;
		end
		bundle.count = k;
	end

	assign step            = accept && !cmd;
	assign load            = step;
	assign trail_ctl.clear = step && start;
	assign trail_ctl.wr_en = step && light;
	assign trail_ctl.rd_en = step;
	assign wr_addr         = head_e;
	assign wr_data         = (stroke == NONE_STROKE) ? 8'd0 : {1'b1, pixel};
	assign rd_addr         = tail_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q   <= 8'd0;
			sweeping_q      <= 1'b0;
			colon_next_on_q <= 1'b0;
			head_q          <= '0;
			tail_q          <= '0;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				digits_q[i] <= 4'd0;
			end
		end else if (accept) begin
			if (cmd) begin
				sweeping_q    <= 1'b0;
				frame_count_q <= 8'd0;
			end else begin
				digits_q      <= digits_e;
				frame_count_q <= fc_e + 8'd1;
				tail_q        <= tail_n;
				head_q        <= (light || in_sweep) ? inc_wrap(head_e) : head_e;
				sweeping_q    <= light || in_sweep;
				if (colon) begin
					colon_next_on_q <= !colon_next_on_q;
				end
			end
		end
	end
endmodule

[sv/ssca_out.sv]
// Result register: holds one tick's results and sends them one per transaction.
`timescale 1ns / 1ps

module ssca_out
	import ssca_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  bundle_t    bundle,
	output logic       in_ready,
	ssca_res_if.source result
);
	result_t [MAX_RESULTS-1:0] res_q;
	logic [1:0]                cnt_q;
	logic                      take;

	assign take                = (cnt_q != 2'd0) && result.ready;
	assign in_ready            = (cnt_q == 2'd0) || (cnt_q == 2'd1 && result.ready);
	assign result.valid        = (cnt_q != 2'd0);
	assign result.action       = res_q[0].action;
	assign result.common_line  = res_q[0].common_line;
	assign result.segment_line = res_q[0].segment_line;
	assign result.last         = (cnt_q == 2'd1);

	always_ff @(posedge clk) begin
		if (load && bundle.count != 2'd0) begin
			res_q <= bundle.res;
		end else if (take) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load && bundle.count != 2'd0) begin
			cnt_q <= bundle.count;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

`ifndef SYNTHESIS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && take)))
		else $error("tick loaded over pending results");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		(load && bundle.count != 2'd0) |=> (cnt_q == $past(bundle.count)))
		else $error("result count not loaded");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cnt_q > 2'd1) |=> (cnt_q == $past(cnt_q) - 2'd1))
		else $error("result count did not advance");
`endif
endmodule

[sv/segment_sweep_clock_animator_core.sv]
// A tick's first result is registered and offered in the cycle after the tick is accepted.
// Throughput: one tick per cycle while each tick gives at most one result and the output
// is ready; the single output register holds the input until a tick's last result is taken.
// Reset: arst_n clears the sweep state, trail written bits and result count at once;
// sweep_frames resets to 64. No clearing pass is needed.
`timescale 1ns / 1ps

module segment_sweep_clock_animator_core
	import ssca_pkg::*;
#(
	parameter int TRAIL_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	ssca_tick_if.sink   tick,
	ssca_res_if.source  result
);
	localparam int AW = $clog2(TRAIL_DEPTH);

	logic [7:0]    sweep_frames_q;
	logic          accept;
	logic          in_ready;
	logic [7:0]    slot;
	trail_ctl_t    trail_ctl;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [AW-1:0] rd_addr;
	logic          load;
	bundle_t       bundle;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SWEEP_FRAMES) ? {24'd0, sweep_frames_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_frames_q <= SWEEP_FRAMES_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SWEEP_FRAMES) begin
			sweep_frames_q <= pwdata[7:0];
		end
	end

	assign tick.ready = in_ready;
	assign accept     = tick.valid && in_ready;

	ssca_step #(
		.TRAIL_DEPTH(TRAIL_DEPTH)
	) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.sweep_frames(sweep_frames_q),
		.accept      (accept),
		.cmd         (tick.cmd),
		.hour        (tick.hour),
		.minute      (tick.minute),
		.second      (tick.second),
		.slot        (slot),
		.trail_ctl   (trail_ctl),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_addr     (rd_addr),
		.load        (load),
		.bundle      (bundle)
	);

	ssca_trail #(
		.TRAIL_DEPTH(TRAIL_DEPTH)
	) u_trail (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (trail_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.slot   (slot)
	);

	ssca_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.bundle  (bundle),
		.in_ready(in_ready),
		.result  (result)
	);
endmodule

[dv/tb_segment_sweep_clock_animator_core.sv]
// Self-checking testbench for the segment sweep clock animator: directed and random ticks.
`timescale 1ns / 1ps

module tb_segment_sweep_clock_animator_core;
	import ssca_pkg::*;

	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_RESTART = 1'b1;
	localparam logic [2:0] NO_SEG = 3'd7;
	localparam logic [7:0] FADE_FRAMES = 8'd16;
	localparam logic [2:0] SWEEP_FRAMES_ADDR = {REG_SWEEP_FRAMES, 2'b00};
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int NUM_PHASES = 5;

	typedef struct packed {
		action_t    action;
		logic [1:0] common_line;
		logic [4:0] segment_line;
		logic       last;
	} disp_action_t;

	typedef struct packed {
		logic               cmd;
		logic [4:0]         hour;
		logic [5:0]         minute;
		logic [5:0]         second;
		logic               typed;
		logic [1:0]         n_res;
		disp_action_t [0:2] res;
	} stim_row_t;

	localparam disp_action_t COLON_OFF_MID = '{ACT_COLON_OFF, 2'd0, 5'd0, 1'b0};
	localparam disp_action_t COLON_ON_MID  = '{ACT_COLON_ON, 2'd0, 5'd0, 1'b0};
	localparam disp_action_t SET_1_18_END  = '{ACT_SET, 2'd1, 5'd18, 1'b1};
	localparam disp_action_t SET_2_19_END  = '{ACT_SET, 2'd2, 5'd19, 1'b1};

	localparam int NUM_DIRECTED = 23;
	localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
		'{CMD_TICK,    5'd23, 6'd59, 6'd59, 1'b1, 2'd2, '{COLON_OFF_MID, SET_1_18_END, '0}},
		'{CMD_RESTART, 5'd0,  6'd0,  6'd0,  1'b1, 2'd0, '0},
		'{CMD_TICK,    5'd31, 6'd63, 6'd63, 1'b1, 2'd2, '{COLON_ON_MID, SET_1_18_END, '0}},
		'{CMD_TICK,    5'd0,  6'd0,  6'd0,  1'b0, 2'd0, '0},
		'{CMD_TICK,    5'd12, 6'd34, 6'd56, 1'b0, 2'd0, '0},
		'{CMD_TICK,    5'd5,  6'd9,  6'd9,  1'b0, 2'd0, '0},
		'{CMD_RESTART, 5'd31, 6'd63, 6'd63, 1'b1, 2'd0, '0},
		'{CMD_TICK,    5'd0,  6'd0,  6'd0,  1'b1, 2'd2, '{COLON_OFF_MID, SET_1_18_END, '0}},
		'{CMD_TICK,    5'd1,  6'd2,  6'd3,  1'b0, 2'd0, '0},
		'{CMD_TICK,    5'd16, 6'd8,  6'd47, 1'b0, 2'd0, '0},
		'{CMD_TICK,    5'd9,  6'd0,  6'd59, 1'b0, 2'd0, '0},
		'{CMD_TICK,    5'd20, 6'd30, 6'd40, 1'b0, 2'd0, '0},
		'{CMD_TICK,    5'd7,  6'd7,  6'd7,  1'b0, 2'd0, '0},
		'{CMD_TICK,    5'd19, 6'd45, 6'd15, 1'b0, 2'd0, '0},
		'{CMD_TICK,    5'd8,  6'd20, 6'd33, 1'b0, 2'd0, '0},
		'{CMD_TICK,    5'd2,  6'd11, 6'd58, 1'b0, 2'd0, '0},
		'{CMD_RESTART, 5'd0,  6'd0,  6'd0,  1'b1, 2'd0, '0},
		'{CMD_RESTART, 5'd0,  6'd0,  6'd0,  1'b1, 2'd0, '0},
		'{CMD_TICK,    5'd12, 6'd34, 6'd56, 1'b1, 2'd2, '{COLON_ON_MID, SET_2_19_END, '0}},
		'{CMD_TICK,    5'd24, 6'd60, 6'd60, 1'b0, 2'd0, '0},
		'{CMD_TICK,    5'd3,  6'd3,  6'd3,  1'b0, 2'd0, '0},
		'{CMD_TICK,    5'd11, 6'd11, 6'd11, 1'b0, 2'd0, '0},
		'{CMD_TICK,    5'd22, 6'd22, 6'd22, 1'b0, 2'd0, '0}
	};

	// segment order per digit value, A..G as 0..6
	localparam logic [2:0] STROKE_ORDER [10][8] = '{
		'{3'd0, 3'd7, 3'd5, 3'd1, 3'd3, 3'd4, 3'd7, 3'd2},
		'{3'd1, 3'd7, 3'd7, 3'd7, 3'd2, 3'd7, 3'd7, 3'd7},
		'{3'd0, 3'd1, 3'd6, 3'd4, 3'd7, 3'd7, 3'd7, 3'd3},
		'{3'd0, 3'd1, 3'd6, 3'd7, 3'd7, 3'd7, 3'd2, 3'd3},
		'{3'd5, 3'd7, 3'd6, 3'd1, 3'd7, 3'd7, 3'd7, 3'd2},
		'{3'd0, 3'd7, 3'd5, 3'd7, 3'd6, 3'd7, 3'd2, 3'd3},
		'{3'd0, 3'd7, 3'd5, 3'd4, 3'd3, 3'd2, 3'd7, 3'd6},
		'{3'd0, 3'd7, 3'd7, 3'd1, 3'd7, 3'd7, 3'd2, 3'd7},
		'{3'd0, 3'd5, 3'd6, 3'd2, 3'd3, 3'd4, 3'd7, 3'd1},
		'{3'd0, 3'd5, 3'd6, 3'd1, 3'd7, 3'd7, 3'd2, 3'd3}
	};

	// {common, segment} per digit position and segment
	localparam logic [6:0] SEG_PIXEL [6][7] = '{
		'{{2'd1, 5'd18}, {2'd2, 5'd19}, {2'd0, 5'd19}, {2'd1, 5'd18},
		  {2'd0, 5'd18}, {2'd2, 5'd18}, {2'd1, 5'd19}},
		'{{2'd2, 5'd20}, {2'd2, 5'd21}, {2'd1, 5'd21}, {2'd0, 5'd21},
		  {2'd0, 5'd20}, {2'd1, 5'd17}, {2'd1, 5'd20}},
		'{{2'd0, 5'd22}, {2'd2, 5'd23}, {2'd0, 5'd23}, {2'd0, 5'd22},
		  {2'd1, 5'd22}, {2'd2, 5'd22}, {2'd1, 5'd23}},
		'{{2'd2, 5'd1},  {2'd2, 5'd10}, {2'd0, 5'd1},  {2'd0, 5'd0},
		  {2'd1, 5'd0},  {2'd2, 5'd0},  {2'd1, 5'd1}},
		'{{2'd2, 5'd2},  {2'd2, 5'd3},  {2'd0, 5'd4},  {2'd0, 5'd3},
		  {2'd0, 5'd2},  {2'd1, 5'd2},  {2'd1, 5'd3}},
		'{{2'd2, 5'd4},  {2'd2, 5'd5},  {2'd1, 5'd6},  {2'd0, 5'd6},
		  {2'd0, 5'd5},  {2'd1, 5'd4},  {2'd1, 5'd5}}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ssca_tick_if tick_ch();
	ssca_res_if  res_ch();

	segment_sweep_clock_animator_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.tick(tick_ch),
		.result(res_ch)
	);

	always #5 clk = ~clk;

	logic [7:0]   sweep_len;
	logic [7:0]   frame_cnt;
	logic         in_sweep;
	logic         colon_on_next;
	logic [3:0]   digit_val [6];
	logic [3:0]   trail_wr;
	logic [3:0]   trail_rd;
	logic [7:0]   trail_mem [16];
	disp_action_t pending_actions [$];
	int           mismatch_cnt = 0;
	int           quiet_cycles = 0;
	int           stall_left = 0;
	bit           calm = 1'b0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 20);
	endfunction

	function automatic void note_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) begin
			$display("%s", msg);
		end
	endfunction

	function automatic void advance_animator(input logic c, input logic [4:0] h,
			input logic [5:0] mi, input logic [5:0] se, output disp_action_t acts [$]);
		logic [7:0] slot;
		logic [7:0] bound;
		logic [2:0] pos;
		logic [2:0] stroke;
		logic [6:0] px;
		acts = {};
		if (c == CMD_RESTART) begin
			in_sweep = 1'b0;
			frame_cnt = 8'd0;
			return;
		end
		if (!in_sweep) begin
			digit_val[0] = 4'(h / 10);
			digit_val[1] = 4'(h % 10);
			digit_val[2] = 4'(mi / 10);
			digit_val[3] = 4'(mi % 10);
			digit_val[4] = 4'(se / 10);
			digit_val[5] = 4'(se % 10);
			frame_cnt = 8'd0;
			in_sweep = 1'b1;
			trail_wr = 4'd0;
			trail_rd = 4'd0;
			foreach (trail_mem[i]) begin
				trail_mem[i] = 8'h00;
			end
		end
		// drop the oldest slot once the trail is full
		if (4'(trail_wr + 4'd1) == trail_rd) begin
			slot = trail_mem[trail_rd];
			if (slot[7]) begin
				acts.push_back('{ACT_CLEAR, slot[6:5], slot[4:0], 1'b0});
			end
			trail_rd = trail_rd + 4'd1;
		end
		if (frame_cnt[4:0] == 5'd0) begin
			acts.push_back('{colon_on_next ? ACT_COLON_ON : ACT_COLON_OFF, 2'd0, 5'd0, 1'b0});
			colon_on_next = !colon_on_next;
		end
		bound = sweep_len - FADE_FRAMES;
		if (frame_cnt < bound) begin
			pos = 3'((frame_cnt / 8) % 6);
			stroke = STROKE_ORDER[digit_val[pos]][frame_cnt[2:0]];
			if (stroke == NO_SEG) begin
				trail_mem[trail_wr] = 8'h00;
			end else begin
				px = SEG_PIXEL[pos][stroke];
				acts.push_back('{ACT_SET, px[6:5], px[4:0], 1'b0});
				trail_mem[trail_wr] = {1'b1, px};
			end
			trail_wr = trail_wr + 4'd1;
		end else if (frame_cnt < sweep_len) begin
			trail_wr = trail_wr + 4'd1;
		end else begin
			in_sweep = 1'b0;
		end
		frame_cnt = frame_cnt + 8'd1;
		if (acts.size() > 0) begin
			acts[acts.size() - 1].last = 1'b1;
		end
	endfunction

	task automatic apb_xfer(input logic wr, input logic [7:0] wdata, output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= SWEEP_FRAMES_ADDR;
		pwdata <= 32'(wdata);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic program_sweep_frames(input logic [7:0] v);
		logic [31:0] rd;
		apb_xfer(1'b1, v, rd);
		apb_xfer(1'b0, 8'd0, rd);
		if (rd[7:0] !== v) begin
			note_mismatch($sformatf("sweep_frames readback: expected %0d got %0d", v, rd[7:0]));
		end
		sweep_len = v;
	endtask

	task automatic send_tick(input logic c, input logic [4:0] h, input logic [5:0] mi,
			input logic [5:0] se);
		int g;
		g = calm ? 0 : pick_gap();
		if (g > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.cmd <= c;
		tick_ch.hour <= h;
		tick_ch.minute <= mi;
		tick_ch.second <= se;
		@(posedge clk);
		while (!tick_ch.ready) begin
			@(posedge clk);
		end
	endtask

	task automatic drain_results();
		while (pending_actions.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			res_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			res_ch.ready <= 1'b1;
			if (!calm) begin
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		disp_action_t got;
		disp_action_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{action_t'(res_ch.action), res_ch.common_line, res_ch.segment_line,
				res_ch.last};
			if (pending_actions.size() == 0) begin
				note_mismatch($sformatf("unexpected result %p", got));
			end else begin
				want = pending_actions.pop_front();
				if (got !== want) begin
					note_mismatch($sformatf("result mismatch: expected %p got %p", want, got));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL segment_sweep_clock_animator_core");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0]  rd;
		disp_action_t acts [$];
		stim_row_t    row;
		logic [7:0]   phase_frames [NUM_PHASES];
		int           phase_items [NUM_PHASES];
		int           restart_pct [NUM_PHASES];
		logic         c;
		logic [4:0]   h;
		logic [5:0]   mi;
		logic [5:0]   se;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		tick_ch.valid <= 1'b0;
		tick_ch.cmd <= CMD_TICK;
		tick_ch.hour <= '0;
		tick_ch.minute <= '0;
		tick_ch.second <= '0;

		sweep_len = SWEEP_FRAMES_RESET;
		frame_cnt = 8'd0;
		in_sweep = 1'b0;
		colon_on_next = 1'b0;
		trail_wr = 4'd0;
		trail_rd = 4'd0;
		foreach (digit_val[i]) begin
			digit_val[i] = 4'd0;
		end
		foreach (trail_mem[i]) begin
			trail_mem[i] = 8'h00;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		apb_xfer(1'b0, 8'd0, rd);
		if (rd[7:0] !== SWEEP_FRAMES_RESET) begin
			note_mismatch($sformatf("sweep_frames after reset: expected %0d got %0d",
				SWEEP_FRAMES_RESET, rd[7:0]));
		end

		for (int k = 0; k < NUM_DIRECTED; k++) begin
			row = DIRECTED[k];
			send_tick(row.cmd, row.hour, row.minute, row.second);
			advance_animator(row.cmd, row.hour, row.minute, row.second, acts);
			if (row.typed) begin
				for (int j = 0; j < row.n_res; j++) begin
					pending_actions.push_back(row.res[j]);
				end
			end else begin
				foreach (acts[j]) begin
					pending_actions.push_back(acts[j]);
				end
			end
		end
		tick_ch.valid <= 1'b0;

		// start at the top setting, then short and wrapped lighting bounds, then a random one from 32 to 64
		phase_frames = '{8'd255, 8'd16, 8'd0, 8'd9, 8'($urandom_range(32, 64))};
		phase_items = '{80, 40, 25, 25, 87};
		restart_pct = '{0, 8, 5, 10, 3};

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			program_sweep_frames(phase_frames[p]);
			for (int k = 0; k < phase_items[p]; k++) begin
				if (k % 32 == 0) begin
					calm = ($urandom_range(0, 3) == 0);
				end
				c = ($urandom_range(0, 99) < restart_pct[p]) ? CMD_RESTART : CMD_TICK;
				h = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
					: 5'($urandom_range(0, 23));
				mi = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
					: 6'($urandom_range(0, 59));
				se = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
					: 6'($urandom_range(0, 59));
				send_tick(c, h, mi, se);
				advance_animator(c, h, mi, se, acts);
				foreach (acts[j]) begin
					pending_actions.push_back(acts[j]);
				end
			end
			tick_ch.valid <= 1'b0;
		end
		calm = 1'b0;

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0 && pending_actions.size() == 0) begin
			$display("PASS segment_sweep_clock_animator_core");
		end else begin
			$display("FAIL segment_sweep_clock_animator_core");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/ssca_pkg.sv
sv/ssca_tick_if.sv
sv/ssca_res_if.sv
sv/ssca_trail.sv
sv/ssca_step.sv
sv/ssca_out.sv
sv/segment_sweep_clock_animator_core.sv
dv/tb_segment_sweep_clock_animator_core.sv
